FILE: rtl/brf_pkg.sv
package brf_pkg;

  // Fixed widths of the data fields
  localparam int unsigned POINT_W     = 32;
  localparam int unsigned RESID_W     = 64;
  localparam int unsigned SPAN_W      = POINT_W + 1;
  localparam int unsigned TOL_W       = 31;
  localparam int unsigned STEP_W      = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Default fraction bits of the fixed-point format
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONST  = 2'd3;

  // Configuration reset values
  localparam logic [TOL_W-1:0]          TOLERANCE_RST   = 31'd3;
  localparam logic [STEP_W-1:0]         MAX_ITER_RST    = 10'd99;
  localparam logic signed [POINT_W-1:0] COEF_LINEAR_RST = 32'sd1638;
  localparam logic signed [POINT_W-1:0] COEF_CONST_RST  = -32'sd262144;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture interval ends
    logic square;     // x*x term
    logic linear;     // k1*x term
    logic sum_first;  // f at the lower end
    logic sum_step;   // f at the midpoint
    logic midpoint;   // new midpoint, step count up
    logic decide;     // move one end, halve the width
    logic publish;    // load the output word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic stop;       // converged or at the step limit
  } status_t;

  // Controller states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQUARE = 7'b0000010,
    ST_LINEAR = 7'b0000100,
    ST_SUM    = 7'b0001000,
    ST_MID    = 7'b0010000,
    ST_DECIDE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

endpackage

FILE: rtl/brf_datapath.sv
module brf_datapath
  import brf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [POINT_W-1:0]    left_end,
  input  logic signed [POINT_W-1:0]    right_end,
  input  cmd_t                         cmd,
  output status_t                      status,
  output logic signed [POINT_W-1:0]    root,
  output logic [STEP_W-1:0]            halves,
  output logic                         limit_reached
);

  // Configuration registers
  logic [TOL_W-1:0]          tolerance;
  logic [STEP_W-1:0]         max_iterations;
  logic signed [POINT_W-1:0] coef_linear;
  logic signed [POINT_W-1:0] coef_const;

  // Search state
  logic signed [POINT_W-1:0] lower_point;
  logic signed [POINT_W-1:0] upper_point;
  logic signed [RESID_W-1:0] lower_residual;
  logic signed [SPAN_W-1:0]  half_width;
  logic [STEP_W-1:0]         step_count;
  logic signed [POINT_W-1:0] eval_x;
  logic signed [RESID_W-1:0] sq_term;
  logic signed [RESID_W-1:0] lin_term;
  logic signed [RESID_W-1:0] resid;

  // Combinational terms
  logic signed [POINT_W-1:0] mul_a;
  logic signed [RESID_W-1:0] prod;
  logic signed [RESID_W-1:0] f_sum;
  logic signed [SPAN_W-1:0]  end_sum;
  logic signed [SPAN_W-1:0]  span_half;
  logic [RESID_W-1:0]        resid_mag;
  logic [STEP_W-1:0]         limit;
  logic                      converged;
  logic                      same_sign;
  logic                      lower_pos, lower_neg, resid_pos, resid_neg;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOLERANCE_RST;
      max_iterations <= MAX_ITER_RST;
      coef_linear    <= COEF_LINEAR_RST;
      coef_const     <= COEF_CONST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE:   tolerance      <= cfg_data[TOL_W-1:0];
        CFG_MAX_ITER:    max_iterations <= cfg_data[STEP_W-1:0];
        CFG_COEF_LINEAR: coef_linear    <= $signed(cfg_data);
        CFG_COEF_CONST:  coef_const     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Shared multiplier: x*x on the square step, k1*x on the linear step
  assign mul_a = cmd.square ? eval_x : coef_linear;
  assign prod  = RESID_W'(mul_a) * RESID_W'(eval_x);
  assign f_sum = sq_term + lin_term + RESID_W'(coef_const);

  // Midpoint with floor rounding
  assign end_sum   = SPAN_W'(lower_point) + SPAN_W'(upper_point);
  assign span_half = half_width >>> 1;

  // Stop test
  assign resid_mag = resid[RESID_W-1] ? RESID_W'(-resid) : RESID_W'(resid);
  assign limit     = (max_iterations == '0) ? STEP_W'(1) : max_iterations;
  assign converged = (resid_mag < RESID_W'(tolerance)) &&
                     (span_half < $signed({2'b00, tolerance}));
  assign status.stop = converged || (step_count >= limit);

  // Sign comparison of f(lower) and f(mid)
  assign lower_pos = !lower_residual[RESID_W-1] && (lower_residual != '0);
  assign lower_neg = lower_residual[RESID_W-1];
  assign resid_pos = !resid[RESID_W-1] && (resid != '0);
  assign resid_neg = resid[RESID_W-1];
  assign same_sign = (lower_pos && resid_pos) || (lower_neg && resid_neg);

  // Search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lower_point <= left_end;
      upper_point <= right_end;
      half_width  <= SPAN_W'(right_end) - SPAN_W'(left_end);
      step_count  <= '0;
      eval_x      <= left_end;
    end
    if (cmd.square) sq_term  <= prod >>> FRAC_BITS;
    if (cmd.linear) lin_term <= prod >>> FRAC_BITS;
    if (cmd.sum_first) lower_residual <= f_sum;
    if (cmd.sum_step)  resid <= f_sum;
    if (cmd.midpoint) begin
      eval_x     <= end_sum[SPAN_W-1:1];
      step_count <= step_count + STEP_W'(1);
    end
    if (cmd.decide) begin
      if (same_sign) begin
        lower_point    <= eval_x;
        lower_residual <= resid;
      end else begin
        upper_point <= eval_x;
      end
      half_width <= span_half;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      root          <= eval_x;
      halves        <= step_count;
      limit_reached <= (step_count == limit);
    end
  end

  // Steps stay within the limit
  a_step_in_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (step_count != '0) && (step_count <= limit))
    else $error("step count outside limit at decide");

  a_mid_count: assert property (@(posedge clk) disable iff (rst)
    cmd.midpoint |=> step_count == $past(step_count) + STEP_W'(1))
    else $error("step count not advanced by midpoint");

endmodule

FILE: rtl/brf_control.sv
module brf_control
  import brf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   first, first_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    first_next = first;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          first_next = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_LINEAR;
      end
      ST_LINEAR: begin
        cmd.linear = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        first_next = 1'b0;
        if (first) begin
          cmd.sum_first = 1'b1;
          state_next    = ST_MID;
        end else begin
          cmd.sum_step = 1'b1;
          state_next   = ST_DECIDE;
        end
      end
      ST_MID: begin
        cmd.midpoint = 1'b1;
        state_next   = ST_SQUARE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.stop ? ST_FINISH : ST_MID;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("output word overwritten before taken");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready && first)
    else $error("ready after accept");

  a_stop_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && status.stop) |=> state == ST_FINISH)
    else $error("stop did not end the search");

endmodule

FILE: rtl/bisection_root_finder.sv
// Bisection root finder for f(x) = x*x + coef_linear*x + coef_const in signed
// fixed point (FRAC_BITS fraction bits, Q16.16 by default). Each input word
// gives an interval; the block bisects it until both |f(mid)| and the interval
// width drop below tolerance, or until max_iterations steps (0 acts as 1), and
// returns the last midpoint, the step count and a flag set when the count
// equals the limit. One search runs at a time. Each step has a midpoint state,
// two passes through the single 32x32 multiplier for x*x and k1*x, a sum state
// and a decision state; evaluating f at the lower end adds a square, a linear
// and a sum pass up front. A finished result sits in an output register and is
// loaded once that register is free; the next word is accepted as soon as the
// result is loaded there, as out_valid rises. Configuration is to be written
// only while idle; the block itself does not enforce it.
module bisection_root_finder
  import brf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [POINT_W-1:0] left_end,
  input  logic signed [POINT_W-1:0] right_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POINT_W-1:0] root,
  output logic [STEP_W-1:0]         halves,
  output logic                      limit_reached
);

  cmd_t    cmd;
  status_t status;

  brf_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  brf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_end      (left_end),
    .right_end     (right_end),
    .cmd           (cmd),
    .status        (status),
    .root          (root),
    .halves        (halves),
    .limit_reached (limit_reached)
  );

endmodule
